FILE: rtl/core/hcpp_pkg.sv
// ---------------------------------------------------------------------------
// hcpp_pkg: shared types and constants of the hex color pair parser
// Character codes, token length codes and the result and state records.
// ---------------------------------------------------------------------------
`default_nettype none

package hcpp_pkg;

  localparam int unsigned ColorW  = 32;
  localparam int unsigned CharW   = 8;
  localparam int unsigned LenW    = 4;

  localparam logic [CharW-1:0] CHAR_EQUALS = 8'h3D;
  localparam logic [CharW-1:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

  // token lengths that decode to a color, and the saturating length limit
  localparam logic [LenW-1:0] LEN_RGB_NIB  = 4'd3;
  localparam logic [LenW-1:0] LEN_RGBA_NIB = 4'd4;
  localparam logic [LenW-1:0] LEN_RGB_BYTE = 4'd6;
  localparam logic [LenW-1:0] LEN_RGBA_BYTE = 4'd8;
  localparam logic [LenW-1:0] LEN_MAX      = 4'd15;

  typedef struct packed {
    logic [ColorW-1:0] nibbles;
    logic [LenW-1:0]   length;
    logic              in_target;
    logic [ColorW-1:0] held_source;
    logic              stopped;
  } parse_state_t;

  typedef struct packed {
    logic              has_pair;
    logic [ColorW-1:0] source_color;
    logic [ColorW-1:0] target_color;
    logic              parse_error;
    logic              stream_done;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/hcpp_step.sv
// ---------------------------------------------------------------------------
// hcpp_step: per-character parse step
// Combinational next state and optional result for one accepted character.
// ---------------------------------------------------------------------------
`default_nettype none

module hcpp_step (
  input  wire hcpp_pkg::parse_state_t     state_i,
  input  wire logic [hcpp_pkg::CharW-1:0] char_code_i,
  input  wire logic                       final_char_i,
  output hcpp_pkg::parse_state_t state_o,
  output hcpp_pkg::result_t      result_o,
  output logic                   emit_o
);

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return d;
  endfunction

  logic                             sep;
  logic [hcpp_pkg::ColorW-1:0]      nib_new;
  logic [hcpp_pkg::LenW-1:0]        len_new;
  logic                             tok_end;
  logic                             tok_ok;
  logic [hcpp_pkg::ColorW-1:0]      color;
  hcpp_pkg::parse_state_t           st;
  hcpp_pkg::result_t                res;
  logic                             emit;

  assign sep = (char_code_i == hcpp_pkg::CHAR_EQUALS) || (char_code_i == hcpp_pkg::CHAR_SEMI);

  always_comb begin
    nib_new = state_i.nibbles;
    len_new = state_i.length;
    if (!sep) begin
      nib_new = {state_i.nibbles[hcpp_pkg::ColorW-5:0], hex_digit(char_code_i)};
      if (state_i.length != hcpp_pkg::LEN_MAX) begin
        len_new = state_i.length + 4'd1;
      end
    end
  end

  // decode by length; a nibble doubled to a byte is the nibble repeated
  always_comb begin
    tok_ok = 1'b1;
    color  = '0;
    unique case (len_new)
      hcpp_pkg::LEN_RGB_NIB: begin
        color = {nib_new[11:8], nib_new[11:8], nib_new[7:4], nib_new[7:4],
                 nib_new[3:0], nib_new[3:0], hcpp_pkg::ALPHA_OPAQUE};
      end
      hcpp_pkg::LEN_RGBA_NIB: begin
        color = {nib_new[15:12], nib_new[15:12], nib_new[11:8], nib_new[11:8],
                 nib_new[7:4], nib_new[7:4], nib_new[3:0], nib_new[3:0]};
      end
      hcpp_pkg::LEN_RGB_BYTE: color = {nib_new[23:0], hcpp_pkg::ALPHA_OPAQUE};
      hcpp_pkg::LEN_RGBA_BYTE: color = nib_new;
      default: tok_ok = 1'b0;
    endcase
  end

  assign tok_end = (sep || final_char_i) && (len_new != '0);

  always_comb begin
    st      = state_i;
    res     = '0;
    emit    = 1'b0;
    if (state_i.stopped) begin
      // drop everything up to the last mark, which restarts the parser
      if (final_char_i) begin
        st = '0;
      end
    end else begin
      st.nibbles = nib_new;
      st.length  = len_new;
      if (tok_end) begin
        if (tok_ok) begin
          if (state_i.in_target) begin
            res.has_pair     = 1'b1;
            res.source_color = state_i.held_source;
            res.target_color = color;
            emit             = 1'b1;
            st.in_target     = 1'b0;
          end else begin
            st.held_source = color;
            st.in_target   = 1'b1;
          end
        end else begin
          // bad source token at the very end stops quietly
          res.parse_error = state_i.in_target || !final_char_i;
          res.stream_done = 1'b1;
          emit            = 1'b1;
        end
        st.nibbles = '0;
        st.length  = '0;
      end
      if (final_char_i) begin
        res.stream_done = 1'b1;
        emit            = 1'b1;
        st              = '0;
      end else if (res.stream_done) begin
        st.stopped = 1'b1;
      end
    end
  end

  assign state_o  = st;
  assign result_o = res;
  assign emit_o   = emit;

endmodule

`default_nettype wire

FILE: rtl/core/hcpp_skid.sv
// ---------------------------------------------------------------------------
// hcpp_skid: result output register with skid stage
// Holds results under output stall; raises full when both entries are taken.
// ---------------------------------------------------------------------------
`default_nettype none

module hcpp_skid (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire hcpp_pkg::result_t push_data_i,
  output logic               full_o,
  output logic               out_valid_o,
  output hcpp_pkg::result_t  out_data_o,
  input  wire logic          out_stall_i
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  hcpp_pkg::result_t out_data_q, out_data_d;
  hcpp_pkg::result_t skid_data_q, skid_data_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/hex_color_pair_parser.sv
// ---------------------------------------------------------------------------
// hex_color_pair_parser: streaming parser for hex color replace pairs
// Turns a body of '='/';' separated hex tokens into source/target RGBA pairs.
// ---------------------------------------------------------------------------
// The block takes one character per cycle while in_stall_o is low and can
// accept a new character in every such cycle: the parse state is updated at
// the input transfer by a single step of nibble shift, length count and
// length decode, and any result lands in an output register backed by a
// one-entry skid stage, so a result waits there for the consumer while the
// next characters keep coming. in_stall_o rises only when both output
// entries are occupied. Results appear for a completed pair, for a badly
// sized token (parse_error with stream_done), and for the last character
// (stream_done). After an error or a quiet stop the rest of the body up to
// the last mark is consumed without results; the last mark always returns
// the parser to its reset state for the next body.
// ---------------------------------------------------------------------------
`default_nettype none

module hex_color_pair_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [hcpp_pkg::CharW-1:0]   char_code_i,
  input  wire logic                         final_char_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              has_pair_o,
  output logic [hcpp_pkg::ColorW-1:0]       source_color_o,
  output logic [hcpp_pkg::ColorW-1:0]       target_color_o,
  output logic                              parse_error_o,
  output logic                              stream_done_o
);

  hcpp_pkg::parse_state_t state_q, state_d;
  hcpp_pkg::result_t      step_res;
  hcpp_pkg::result_t      out_res;
  logic                   step_emit;
  logic                   in_xfer;
  logic                   skid_full;

  // accept a character whenever the output side has room for its result
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = skid_full;

  hcpp_step u_step (
    .state_i      (state_q),
    .char_code_i  (char_code_i),
    .final_char_i (final_char_i),
    .state_o      (state_d),
    .result_o     (step_res),
    .emit_o       (step_emit)
  );

  // advance parse state only on an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  hcpp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer && step_emit),
    .push_data_i (step_res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .out_stall_i (out_stall_i)
  );

  assign has_pair_o     = out_res.has_pair;
  assign source_color_o = out_res.source_color;
  assign target_color_o = out_res.target_color;
  assign parse_error_o  = out_res.parse_error;
  assign stream_done_o  = out_res.stream_done;

endmodule

`default_nettype wire

FILE: rtl/core/hcpp_checker.sv
// ---------------------------------------------------------------------------
// hcpp_checker: port-level checks for the hex color pair parser
// Watches the output channel and the consistency of result flags.
// ---------------------------------------------------------------------------
`default_nettype none

module hcpp_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic                       has_pair_o,
  input wire logic [hcpp_pkg::ColorW-1:0] source_color_o,
  input wire logic [hcpp_pkg::ColorW-1:0] target_color_o,
  input wire logic                       parse_error_o,
  input wire logic                       stream_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(source_color_o) && $stable(target_color_o))
    else $error("stalled result changed");

  a_err_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_error_o |-> stream_done_o && !has_pair_o)
    else $error("error result without stream end or with a pair");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> has_pair_o || stream_done_o)
    else $error("empty result");

  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind hex_color_pair_parser hcpp_checker u_hcpp_checker (.*);

`default_nettype wire
